// ----- hdl/asr_pkg.sv -----
package asr_pkg;

    // Depth of the receive buffer unless overridden at the top level
    localparam int FIFO_DEPTH_DEFAULT = 3;

    // Request modes
    localparam logic [1:0] MODE_SAMPLE = 2'd0;
    localparam logic [1:0] MODE_READ   = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] REG_CHAR_BITS  = 3'd0;
    localparam logic [2:0] REG_PARITY_ON  = 3'd1;
    localparam logic [2:0] REG_PARITY_EVN = 3'd2;
    localparam logic [2:0] REG_CLOCK_RATE = 3'd3;
    localparam logic [2:0] REG_IRQ_MODE   = 3'd4;

    // Clock rate codes
    localparam logic [1:0] RATE_X1  = 2'd0;
    localparam logic [1:0] RATE_X16 = 2'd1;
    localparam logic [1:0] RATE_X32 = 2'd2;
    localparam logic [1:0] RATE_X64 = 2'd3;

    // Receive interrupt modes
    localparam logic [1:0] IRQ_OFF   = 2'd0;
    localparam logic [1:0] IRQ_FIRST = 2'd1;
    localparam logic [1:0] IRQ_ALL   = 2'd2;

    // Read data returned when nothing is popped
    localparam logic [7:0] EMPTY_DATA = 8'hFF;

    typedef struct packed {
        logic [1:0] mode;
        logic       line_bit;
    } in_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       char_available;
        logic [1:0] fifo_count;
        logic       parity_error;
        logic       overrun_error;
        logic       framing_error;
        logic       rx_irq;
    } out_item_t;

    typedef struct packed {
        logic [3:0] char_bits;
        logic       parity_on;
        logic       parity_is_even;
        logic [1:0] clock_rate_code;
        logic [1:0] rx_irq_mode;
    } cfg_t;

    // Events from the character framer to the receive buffer
    typedef struct packed {
        logic       store;
        logic [7:0] data;
        logic       parity_err;
        logic       framing_err;
    } rx_event_t;

endpackage

// ----- hdl/asr_framer.sv -----
module asr_framer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic              line_bit,
    input  asr_pkg::cfg_t     cfg,
    output asr_pkg::rx_event_t evt
);
    import asr_pkg::*;

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_START  = 3'd1;
    localparam logic [2:0] PH_DATA   = 3'd2;
    localparam logic [2:0] PH_PARITY = 3'd3;
    localparam logic [2:0] PH_STOP   = 3'd4;

    logic [2:0] phase_reg, phase_next;
    logic [6:0] tick_reg, tick_next;
    logic [3:0] bits_reg, bits_next;
    logic [7:0] shift_reg, shift_next;

    logic [6:0] tpb;
    logic [6:0] tick_inc;
    logic       bit_done;
    logic [3:0] eff_bits;
    logic [7:0] data_mask;
    logic       expect_par;

    // Decode bit time and clamp the character length
    always_comb
    begin
        case (cfg.clock_rate_code)
            RATE_X1:  tpb = 7'd1;
            RATE_X16: tpb = 7'd16;
            RATE_X32: tpb = 7'd32;
            default:  tpb = 7'd64;
        endcase
        if (cfg.char_bits < 4'd5)
            eff_bits = 4'd5;
        else if (cfg.char_bits > 4'd8)
            eff_bits = 4'd8;
        else
            eff_bits = cfg.char_bits;
        case (eff_bits)
            4'd5:    data_mask = 8'h1F;
            4'd6:    data_mask = 8'h3F;
            4'd7:    data_mask = 8'h7F;
            default: data_mask = 8'hFF;
        endcase
    end

    assign tick_inc   = tick_reg + 7'd1;
    assign bit_done   = (tick_inc >= tpb);
    assign expect_par = cfg.parity_is_even ? ^(shift_reg & data_mask)
                                           : ~(^(shift_reg & data_mask));

    // Advance the receive sequence on each line sample
    always_comb
    begin
        phase_next      = phase_reg;
        tick_next       = tick_reg;
        bits_next       = bits_reg;
        shift_next      = shift_reg;
        evt.store       = 1'b0;
        evt.data        = shift_reg;
        evt.parity_err  = 1'b0;
        evt.framing_err = 1'b0;
        if (step)
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (!line_bit)
                    begin
                        phase_next = PH_START;
                        tick_next  = 7'd0;
                        bits_next  = 4'd0;
                        shift_next = 8'd0;
                    end
                end
                PH_START:
                begin
                    tick_next = tick_inc;
                    if (tick_reg >= (tpb >> 1))
                    begin
                        tick_next  = 7'd0;
                        phase_next = line_bit ? PH_IDLE : PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    tick_next = bit_done ? 7'd0 : tick_inc;
                    if (bit_done)
                    begin
                        if (!bits_reg[3])
                            shift_next[bits_reg[2:0]] = line_bit;
                        bits_next = bits_reg + 4'd1;
                        if (bits_next >= eff_bits)
                            phase_next = cfg.parity_on ? PH_PARITY : PH_STOP;
                    end
                end
                PH_PARITY:
                begin
                    tick_next = bit_done ? 7'd0 : tick_inc;
                    if (bit_done)
                    begin
                        evt.parity_err = (line_bit != expect_par);
                        phase_next     = PH_STOP;
                    end
                end
                default:
                begin
                    tick_next = bit_done ? 7'd0 : tick_inc;
                    if (bit_done)
                    begin
                        evt.framing_err = !line_bit;
                        evt.store       = 1'b1;
                        phase_next      = PH_IDLE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            tick_reg  <= 7'd0;
            bits_reg  <= 4'd0;
            shift_reg <= 8'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            bits_reg  <= bits_next;
            shift_reg <= shift_next;
        end
    end

endmodule

// ----- hdl/asr_rxbuf.sv -----
module asr_rxbuf #(
    parameter int FIFO_DEPTH = asr_pkg::FIFO_DEPTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  asr_pkg::rx_event_t  evt,
    input  logic                pop,
    input  logic                clear,
    input  logic [1:0]          irq_mode,
    output asr_pkg::out_item_t  status
);
    import asr_pkg::*;

    localparam int PtrW  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FillW = $clog2(FIFO_DEPTH + 1);
    localparam int SumW  = FillW + 1;
    localparam logic [FillW-1:0] DepthFill = FillW'(FIFO_DEPTH);
    localparam logic [SumW-1:0]  DepthSum  = SumW'(FIFO_DEPTH);
    localparam logic [PtrW-1:0]  LastPtr   = PtrW'(FIFO_DEPTH - 1);

    logic [7:0]       store_mem [FIFO_DEPTH];
    logic [PtrW-1:0]  head_reg, head_next;
    logic [FillW-1:0] fill_reg, fill_next;
    logic [2:0]       err_reg, err_next;
    logic             irq_reg, irq_next;

    logic             full;
    logic             do_write;
    logic             do_pop;
    logic [SumW-1:0]  slot_sum;
    logic [PtrW-1:0]  slot;

    assign full     = (fill_reg == DepthFill);
    assign do_write = evt.store && !full;
    assign do_pop   = pop && (fill_reg != '0);
    assign slot_sum = SumW'(head_reg) + SumW'(fill_reg);
    assign slot     = (slot_sum >= DepthSum) ? PtrW'(slot_sum - DepthSum) : PtrW'(slot_sum);

    // Update pointers, sticky flags and the interrupt
    always_comb
    begin
        head_next = head_reg;
        fill_next = fill_reg;
        irq_next  = irq_reg;
        if (do_write)
        begin
            fill_next = fill_reg + FillW'(1);
            if (irq_mode == IRQ_ALL || (irq_mode == IRQ_FIRST && fill_reg == '0))
                irq_next = 1'b1;
        end
        if (do_pop)
        begin
            head_next = (head_reg == LastPtr) ? '0 : head_reg + PtrW'(1);
            fill_next = fill_reg - FillW'(1);
            irq_next  = 1'b0;
        end
        if (clear)
            err_next = 3'd0;
        else
            err_next = err_reg | {evt.framing_err, evt.store && full, evt.parity_err};
    end

    // Build the status after this request's effect
    always_comb
    begin
        status.read_data      = do_pop ? store_mem[head_reg] : EMPTY_DATA;
        status.char_available = (fill_next != '0);
        status.fifo_count     = 2'(fill_next);
        status.parity_error   = err_next[0];
        status.overrun_error  = err_next[1];
        status.framing_error  = err_next[2];
        status.rx_irq         = irq_next;
    end

    always_ff @(posedge clk)
    begin
        if (do_write)
            store_mem[slot] <= evt.data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            fill_reg <= '0;
            err_reg  <= 3'd0;
            irq_reg  <= 1'b0;
        end
        else
        begin
            head_reg <= head_next;
            fill_reg <= fill_next;
            err_reg  <= err_next;
            irq_reg  <= irq_next;
        end
    end

endmodule

// ----- hdl/async_serial_receiver.sv -----
// Oversampled asynchronous serial receiver. Each request carries a mode: a line
// sample tick (mode 0) advances the character framer by one sampling-clock tick,
// a read (mode 1) pops the receive buffer (0xFF when it is empty), and an error
// reset (mode 2) clears the sticky parity, overrun and framing flags. Every request
// produces exactly one result, which shows the popped data and the status after
// that request. One request is taken per clock cycle; its result appears in the
// result register on the next cycle, and new requests keep flowing while a result
// waits, stalling only when the result register is full and its consumer stalls.
// The buffer needs no clearing pass after reset. Bit time is 1, 16, 32 or 64
// ticks as set by clock_rate_code; configuration takes effect at once.
module async_serial_receiver #(
    parameter int FIFO_DEPTH = asr_pkg::FIFO_DEPTH_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  asr_pkg::in_item_t  item,
    output logic               result_valid,
    input  logic               result_stall,
    output asr_pkg::out_item_t result,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [3:0]         cfg_data
);
    import asr_pkg::*;

    cfg_t      cfg_reg;
    out_item_t result_reg;
    logic      result_valid_reg, result_valid_next;

    logic      accept;
    rx_event_t evt;
    out_item_t status;

    // Take a request unless the held result is stalled
    assign item_stall = result_valid_reg && result_stall;
    assign accept     = item_valid && !item_stall;

    asr_framer u_framer (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (accept && item.mode == MODE_SAMPLE),
        .line_bit (item.line_bit),
        .cfg      (cfg_reg),
        .evt      (evt)
    );

    asr_rxbuf #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_rxbuf (
        .clk      (clk),
        .rst_n    (rst_n),
        .evt      (evt),
        .pop      (accept && item.mode == MODE_READ),
        .clear    (accept && item.mode == MODE_CLEAR),
        .irq_mode (cfg_reg.rx_irq_mode),
        .status   (status)
    );

    // Hold the result until it is taken
    assign result_valid_next = accept || (result_valid_reg && result_stall);

    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else
            result_valid_reg <= result_valid_next;
    end

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.char_bits       <= 4'd5;
            cfg_reg.parity_on       <= 1'b0;
            cfg_reg.parity_is_even  <= 1'b0;
            cfg_reg.clock_rate_code <= RATE_X1;
            cfg_reg.rx_irq_mode     <= IRQ_OFF;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CHAR_BITS:  cfg_reg.char_bits       <= cfg_data;
                REG_PARITY_ON:  cfg_reg.parity_on       <= cfg_data[0];
                REG_PARITY_EVN: cfg_reg.parity_is_even  <= cfg_data[0];
                REG_CLOCK_RATE: cfg_reg.clock_rate_code <= cfg_data[1:0];
                REG_IRQ_MODE:   cfg_reg.rx_irq_mode     <= cfg_data[1:0];
                default:        ;
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ----- tb/tb_async_serial_receiver.sv -----
`timescale 1ns / 1ps

module tb_async_serial_receiver;

    import asr_pkg::*;

    // Mode with no effect on the receiver, status only
    localparam logic [1:0] MODE_NONE = 2'd3;

    // Interrupt mode in which characters raise nothing
    localparam logic [1:0] IRQ_SPECIAL = 2'd3;

    localparam int RANDOM_ITEMS = 280;
    localparam int MAX_REPORTS  = 10;
    localparam int DEPTH        = FIFO_DEPTH_DEFAULT;

    localparam cfg_t CFG_RESET = '{char_bits: 4'd5, parity_on: 1'b0, parity_is_even: 1'b0,
                                   clock_rate_code: RATE_X1, rx_irq_mode: IRQ_OFF};

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_START,
        PH_DATA,
        PH_PARITY,
        PH_STOP
    } line_phase_t;

    typedef enum {
        ROW_FRAME,
        ROW_FALSE_START,
        ROW_READ,
        ROW_CLEAR,
        ROW_NOP,
        ROW_SETUP
    } row_kind_t;

    typedef struct {
        row_kind_t  kind;
        logic [7:0] data;
        bit         par_flip;
        bit         stop_lvl;
        cfg_t       cfg;
        bit         pin_en;
        out_item_t  pin;
    } plan_row_t;

    logic       clk;
    logic       rst_n;
    logic       item_valid;
    logic       item_stall;
    in_item_t   item;
    logic       result_valid;
    logic       result_stall;
    out_item_t  result;
    logic       cfg_we;
    logic [2:0] cfg_index;
    logic [3:0] cfg_data;

    // Fixed expectation that travels alongside the request
    logic       pin_en;
    out_item_t  pin_val;

    // Receiver model state
    line_phase_t ln_phase = PH_IDLE;
    logic [6:0]  ln_ticks = '0;
    logic [3:0]  ln_bits  = '0;
    logic [7:0]  ln_shift = '0;
    logic [7:0]  buf_mem [DEPTH];
    int unsigned buf_head = 0;
    int unsigned buf_fill = 0;
    logic        err_par  = 1'b0;
    logic        err_ovr  = 1'b0;
    logic        err_frm  = 1'b0;
    logic        irq_flag = 1'b0;
    cfg_t        sh_cfg   = CFG_RESET;

    // Stimulus side bookkeeping
    cfg_t        cur_cfg = CFG_RESET;
    out_item_t   status_q [$];
    plan_row_t   plan [$];
    int unsigned sent_count    = 0;
    int unsigned directed_sent = 0;
    int unsigned fails         = 0;
    bit          req_on        = 1'b0;
    bit          quiet         = 1'b0;

    async_serial_receiver u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("tb_async_serial_receiver failed");
        $finish;
    end

    function automatic int unsigned bit_ticks(logic [1:0] rate);
        case (rate)
            RATE_X1:  bit_ticks = 1;
            RATE_X16: bit_ticks = 16;
            RATE_X32: bit_ticks = 32;
            default:  bit_ticks = 64;
        endcase
    endfunction

    // Clamp the character length to 5..8
    function automatic int unsigned char_len(logic [3:0] cb);
        if (cb < 4'd5)
            char_len = 5;
        else if (cb > 4'd8)
            char_len = 8;
        else
            char_len = cb;
    endfunction

    function automatic string status_str(out_item_t s);
        status_str = $sformatf("data=%02h avail=%0b count=%0d par=%0b ovr=%0b frm=%0b irq=%0b",
                               s.read_data, s.char_available, s.fifo_count, s.parity_error,
                               s.overrun_error, s.framing_error, s.rx_irq);
    endfunction

    function automatic out_item_t status_of(logic [7:0] d, bit avail, logic [1:0] cnt,
                                            bit pe, bit oe, bit fe, bit irq);
        out_item_t s;
        s.read_data      = d;
        s.char_available = avail;
        s.fifo_count     = cnt;
        s.parity_error   = pe;
        s.overrun_error  = oe;
        s.framing_error  = fe;
        s.rx_irq         = irq;
        status_of = s;
    endfunction

    function automatic cfg_t cfg_of(logic [3:0] cb, bit pon, bit peven, logic [1:0] rate,
                                    logic [1:0] irq);
        cfg_t c;
        c.char_bits       = cb;
        c.parity_on       = pon;
        c.parity_is_even  = peven;
        c.clock_rate_code = rate;
        c.rx_irq_mode     = irq;
        cfg_of = c;
    endfunction

    // Advance the tick counter; true once a full bit time has passed
    function automatic bit bit_time_up();
        ln_ticks = ln_ticks + 7'd1;
        if (ln_ticks >= bit_ticks(sh_cfg.clock_rate_code))
        begin
            ln_ticks = '0;
            bit_time_up = 1'b1;
        end
        else
            bit_time_up = 1'b0;
    endfunction

    // Place a finished character into the buffer, or flag overrun
    function automatic void push_char();
        if (buf_fill < DEPTH)
        begin
            buf_mem[(buf_head + buf_fill) % DEPTH] = ln_shift;
            buf_fill++;
            if (sh_cfg.rx_irq_mode == IRQ_ALL || (sh_cfg.rx_irq_mode == IRQ_FIRST && buf_fill == 1))
                irq_flag = 1'b1;
        end
        else
            err_ovr = 1'b1;
    endfunction

    // Apply one request to the model and return the status it reports
    function automatic out_item_t next_status(in_item_t req);
        out_item_t   st;
        int unsigned seen;
        int unsigned ones;
        int unsigned nb;
        int unsigned i;
        logic        par_want;
        st.read_data = EMPTY_DATA;
        nb = char_len(sh_cfg.char_bits);
        case (req.mode)
            MODE_SAMPLE:
            begin
                case (ln_phase)
                    PH_IDLE:
                    begin
                        if (!req.line_bit)
                        begin
                            ln_phase = PH_START;
                            ln_ticks = '0;
                            ln_bits  = '0;
                            ln_shift = '0;
                        end
                    end
                    PH_START:
                    begin
                        seen = ln_ticks;
                        ln_ticks = ln_ticks + 7'd1;
                        if (seen >= bit_ticks(sh_cfg.clock_rate_code) / 2)
                        begin
                            ln_ticks = '0;
                            ln_phase = req.line_bit ? PH_IDLE : PH_DATA;
                        end
                    end
                    PH_DATA:
                    begin
                        if (bit_time_up())
                        begin
                            if (ln_bits < 4'd8)
                                ln_shift[ln_bits[2:0]] = req.line_bit;
                            ln_bits = ln_bits + 4'd1;
                            if (ln_bits >= nb)
                                ln_phase = sh_cfg.parity_on ? PH_PARITY : PH_STOP;
                        end
                    end
                    PH_PARITY:
                    begin
                        if (bit_time_up())
                        begin
                            ones = 0;
                            for (i = 0; i < nb; i++)
                                ones += ln_shift[i];
                            par_want = 1'(ones % 2) ^ ~sh_cfg.parity_is_even;
                            if (req.line_bit != par_want)
                                err_par = 1'b1;
                            ln_phase = PH_STOP;
                        end
                    end
                    default:
                    begin
                        if (bit_time_up())
                        begin
                            if (!req.line_bit)
                                err_frm = 1'b1;
                            push_char();
                            ln_phase = PH_IDLE;
                            ln_ticks = '0;
                        end
                    end
                endcase
            end
            MODE_READ:
            begin
                if (buf_fill > 0)
                begin
                    st.read_data = buf_mem[buf_head];
                    buf_head = (buf_head + 1) % DEPTH;
                    buf_fill--;
                    irq_flag = 1'b0;
                end
            end
            MODE_CLEAR:
            begin
                err_par = 1'b0;
                err_ovr = 1'b0;
                err_frm = 1'b0;
            end
            default:
            begin
            end
        endcase
        st.char_available = (buf_fill != 0);
        st.fifo_count     = 2'(buf_fill);
        st.parity_error   = err_par;
        st.overrun_error  = err_ovr;
        st.framing_error  = err_frm;
        st.rx_irq         = irq_flag;
        next_status = st;
    endfunction

    task automatic check_result(out_item_t got);
        out_item_t want;
        string     bad;
        if (status_q.size() == 0)
        begin
            fails++;
            if (fails <= MAX_REPORTS)
                $display("result with no request pending: %s", status_str(got));
        end
        else
        begin
            want = status_q[0];
            status_q.delete(0);
            bad = "";
            if (got.read_data !== want.read_data)
                bad = {bad, " read_data"};
            if (got.char_available !== want.char_available)
                bad = {bad, " char_available"};
            if (got.fifo_count !== want.fifo_count)
                bad = {bad, " fifo_count"};
            if (got.parity_error !== want.parity_error)
                bad = {bad, " parity_error"};
            if (got.overrun_error !== want.overrun_error)
                bad = {bad, " overrun_error"};
            if (got.framing_error !== want.framing_error)
                bad = {bad, " framing_error"};
            if (got.rx_irq !== want.rx_irq)
                bad = {bad, " rx_irq"};
            if (bad != "")
            begin
                fails++;
                if (fails <= MAX_REPORTS)
                    $display("mismatch in%s: expected %s, got %s", bad,
                             status_str(want), status_str(got));
            end
        end
    endtask

    // Track config writes, predict accepted requests, check accepted results
    always @(posedge clk)
    begin : check_results
        out_item_t want;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_CHAR_BITS:  sh_cfg.char_bits       = cfg_data;
                    REG_PARITY_ON:  sh_cfg.parity_on       = cfg_data[0];
                    REG_PARITY_EVN: sh_cfg.parity_is_even  = cfg_data[0];
                    REG_CLOCK_RATE: sh_cfg.clock_rate_code = cfg_data[1:0];
                    REG_IRQ_MODE:   sh_cfg.rx_irq_mode     = cfg_data[1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (item_valid && !item_stall)
            begin
                want = next_status(item);
                if (pin_en)
                    want = pin_val;
                status_q.insert(status_q.size(), want);
            end
            if (result_valid && !result_stall)
                check_result(result);
        end
    end

    // Result side: random stall bursts plus one long hold-off
    initial
    begin : result_sink
        int unsigned burst;
        int unsigned hold_left;
        int unsigned cycle;
        bit          hold_done;
        burst = 0;
        hold_left = 0;
        cycle = 0;
        hold_done = 1'b0;
        result_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            cycle++;
            if (hold_left != 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else if (!hold_done && cycle >= 300 && item_valid)
            begin
                hold_done = 1'b1;
                hold_left = 47;
                result_stall <= 1'b1;
            end
            else if (burst != 0)
            begin
                burst--;
                result_stall <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                burst = $urandom_range(0, 3);
                result_stall <= 1'b1;
            end
            else
                result_stall <= 1'b0;
        end
    end

    // Offer one request and hold it until accepted
    task automatic send_req(logic [1:0] m, logic lvl, bit pen, out_item_t pval);
        if (req_on && !quiet && $urandom_range(0, 5) == 0)
        begin
            item_valid <= 1'b0;
            req_on = 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        item_valid <= 1'b1;
        req_on = 1'b1;
        item <= '{mode: m, line_bit: lvl};
        pin_en <= pen;
        pin_val <= pval;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        sent_count++;
    endtask

    // Drop valid once the last request is taken
    task automatic release_req();
        if (req_on)
        begin
            item_valid <= 1'b0;
            req_on = 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        while (status_q.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_config(cfg_t c);
        logic [2:0] reg_order [5];
        logic [3:0] val;
        int         k;
        reg_order = '{REG_CHAR_BITS, REG_PARITY_ON, REG_PARITY_EVN, REG_CLOCK_RATE, REG_IRQ_MODE};
        for (k = 0; k < 5; k++)
        begin
            case (reg_order[k])
                REG_CHAR_BITS:  val = c.char_bits;
                REG_PARITY_ON:  val = {3'b000, c.parity_on};
                REG_PARITY_EVN: val = {3'b000, c.parity_is_even};
                REG_CLOCK_RATE: val = {2'b00, c.clock_rate_code};
                default:        val = {2'b00, c.rx_irq_mode};
            endcase
            cfg_we <= 1'b1;
            cfg_index <= reg_order[k];
            cfg_data <= val;
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
        cur_cfg = c;
    endtask

    // One line tick, with optional glitches and interleaved reads or clears
    task automatic send_tick(logic lvl, bit noisy, bit mixed, bit pen, out_item_t pval);
        logic lv;
        lv = lvl;
        if (mixed && $urandom_range(0, 19) == 0)
            send_req(($urandom_range(0, 3) != 0) ? MODE_READ : MODE_CLEAR,
                     1'($urandom_range(0, 1)), 1'b0, '0);
        if (noisy && $urandom_range(0, 49) == 0)
            lv = ~lv;
        send_req(MODE_SAMPLE, lv, pen, pval);
    endtask

    // Drive a whole character on the line at the current settings
    task automatic send_frame(logic [7:0] data, bit par_flip, bit stop_lvl, bit noisy, bit mixed,
                              bit pen, out_item_t pval);
        logic        seq [10];
        int unsigned nb;
        int unsigned t;
        int unsigned c;
        int unsigned n;
        int unsigned ones;
        int unsigned i;
        int unsigned k;
        nb = char_len(cur_cfg.char_bits);
        t = bit_ticks(cur_cfg.clock_rate_code);
        c = t / 2 + 1;
        n = 0;
        ones = 0;
        for (i = 0; i < nb; i++)
        begin
            seq[n] = data[i];
            ones += data[i];
            n++;
        end
        if (cur_cfg.parity_on)
        begin
            seq[n] = (1'(ones % 2) ^ ~cur_cfg.parity_is_even) ^ par_flip;
            n++;
        end
        seq[n] = stop_lvl;
        n++;
        // Start bit runs through the confirm tick
        for (i = 0; i <= c; i++)
            send_tick(1'b0, noisy, mixed, 1'b0, '0);
        for (i = 0; i < n; i++)
            for (k = 0; k < t; k++)
                send_tick(seq[i], noisy, mixed, pen && i == n - 1 && k == t - 1, pval);
    endtask

    // Falling edge that is high again at the confirm tick
    task automatic send_false_start();
        int unsigned c;
        int unsigned i;
        c = bit_ticks(cur_cfg.clock_rate_code) / 2 + 1;
        for (i = 0; i < c; i++)
            send_req(MODE_SAMPLE, 1'b0, 1'b0, '0);
        send_req(MODE_SAMPLE, 1'b1, 1'b0, '0);
    endtask

    task automatic add_row(row_kind_t kind, logic [7:0] data, bit flip, bit stop, cfg_t c,
                           bit pen, out_item_t pval);
        plan_row_t r;
        r.kind = kind;
        r.data = data;
        r.par_flip = flip;
        r.stop_lvl = stop;
        r.cfg = c;
        r.pin_en = pen;
        r.pin = pval;
        plan.insert(plan.size(), r);
    endtask

    task automatic build_plan();
        out_item_t none;
        out_item_t blank;
        none = '0;
        blank = status_of(EMPTY_DATA, 0, 0, 0, 0, 0, 0);
        // Reset status on every non-sample mode
        add_row(ROW_READ, 8'h00, 0, 1, CFG_RESET, 1, blank);
        add_row(ROW_NOP, 8'h00, 0, 1, CFG_RESET, 1, blank);
        add_row(ROW_CLEAR, 8'h00, 0, 1, CFG_RESET, 1, blank);
        // All-zero character with a low stop bit: stored with a framing error
        add_row(ROW_FRAME, 8'h00, 0, 0, CFG_RESET, 1, status_of(EMPTY_DATA, 1, 1, 0, 0, 1, 0));
        add_row(ROW_READ, 8'h00, 0, 1, CFG_RESET, 1, status_of(8'h00, 0, 0, 0, 0, 1, 0));
        add_row(ROW_CLEAR, 8'h00, 0, 1, CFG_RESET, 1, blank);
        add_row(ROW_FALSE_START, 8'h00, 0, 1, CFG_RESET, 0, none);
        // Eight bits, even parity, interrupt on first character; fill and overrun
        add_row(ROW_SETUP, 8'h00, 0, 1, cfg_of(4'd8, 1, 1, RATE_X1, IRQ_FIRST), 0, none);
        add_row(ROW_FRAME, 8'hFF, 0, 1, CFG_RESET, 0, none);
        add_row(ROW_FRAME, 8'hA5, 1, 1, CFG_RESET, 0, none);
        add_row(ROW_FRAME, 8'h00, 0, 1, CFG_RESET, 0, none);
        add_row(ROW_FRAME, 8'h5A, 0, 1, CFG_RESET, 0, none);
        add_row(ROW_FRAME, 8'h81, 0, 1, CFG_RESET, 0, none);
        add_row(ROW_READ, 8'h00, 0, 1, CFG_RESET, 0, none);
        add_row(ROW_READ, 8'h00, 0, 1, CFG_RESET, 0, none);
        add_row(ROW_READ, 8'h00, 0, 1, CFG_RESET, 0, none);
        add_row(ROW_READ, 8'h00, 0, 1, CFG_RESET, 1, status_of(EMPTY_DATA, 0, 0, 1, 1, 0, 0));
        add_row(ROW_CLEAR, 8'h00, 0, 1, CFG_RESET, 1, blank);
        // Length below range acts as five bits; odd parity at x16
        add_row(ROW_SETUP, 8'h00, 0, 1, cfg_of(4'd0, 1, 0, RATE_X16, IRQ_ALL), 0, none);
        add_row(ROW_FRAME, 8'h1F, 0, 1, CFG_RESET, 0, none);
        // Length above range acts as eight bits; characters raise no interrupt
        add_row(ROW_SETUP, 8'h00, 0, 1, cfg_of(4'd15, 0, 0, RATE_X1, IRQ_SPECIAL), 0, none);
        add_row(ROW_FRAME, 8'hC3, 0, 1, CFG_RESET, 0, none);
        add_row(ROW_READ, 8'h00, 0, 1, CFG_RESET, 0, none);
        // Start check at the two slowest rates
        add_row(ROW_SETUP, 8'h00, 0, 1, cfg_of(4'd5, 0, 0, RATE_X32, IRQ_OFF), 0, none);
        add_row(ROW_FALSE_START, 8'h00, 0, 1, CFG_RESET, 0, none);
        add_row(ROW_SETUP, 8'h00, 0, 1, cfg_of(4'd5, 0, 0, RATE_X64, IRQ_OFF), 0, none);
        add_row(ROW_FALSE_START, 8'h00, 0, 1, CFG_RESET, 0, none);
        add_row(ROW_SETUP, 8'h00, 0, 1, cfg_of(4'd7, 0, 1, RATE_X1, IRQ_OFF), 0, none);
        add_row(ROW_FRAME, 8'h7F, 0, 1, CFG_RESET, 0, none);
        add_row(ROW_READ, 8'h00, 0, 1, CFG_RESET, 0, none);
    endtask

    task automatic run_row(plan_row_t r);
        case (r.kind)
            ROW_SETUP:
            begin
                release_req();
                wait_idle();
                write_config(r.cfg);
            end
            ROW_FRAME:       send_frame(r.data, r.par_flip, r.stop_lvl, 0, 0, r.pin_en, r.pin);
            ROW_FALSE_START: send_false_start();
            ROW_READ:        send_req(MODE_READ, 1'b0, r.pin_en, r.pin);
            ROW_CLEAR:       send_req(MODE_CLEAR, 1'b1, r.pin_en, r.pin);
            default:         send_req(MODE_NONE, 1'b1, r.pin_en, r.pin);
        endcase
    endtask

    // One random phase: new settings, then a mix of characters and requests
    task automatic run_phase();
        cfg_t        c;
        int unsigned budget;
        int unsigned start;
        int unsigned pick;
        if ($urandom_range(0, 7) == 0)
            c.char_bits = 4'($urandom_range(0, 15));
        else
            c.char_bits = 4'($urandom_range(5, 8));
        c.parity_on = 1'($urandom_range(0, 1));
        c.parity_is_even = 1'($urandom_range(0, 1));
        c.clock_rate_code = ($urandom_range(0, 3) == 0) ? RATE_X16 : RATE_X1;
        c.rx_irq_mode = 2'($urandom_range(0, 3));
        release_req();
        wait_idle();
        write_config(c);
        quiet = (sent_count - directed_sent) >= RANDOM_ITEMS - 100;
        start = sent_count;
        budget = $urandom_range(60, 110);
        while (sent_count - start < budget)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
                send_frame(8'($urandom), $urandom_range(0, 9) == 0, $urandom_range(0, 9) != 0,
                           $urandom_range(0, 3) == 0, 1, 0, '0);
            else if (pick < 58)
                repeat ($urandom_range(1, 4)) send_req(MODE_SAMPLE, 1'b1, 1'b0, '0);
            else if (pick < 63)
                send_false_start();
            else if (pick < 68)
                repeat ($urandom_range(1, 6))
                    send_req(MODE_SAMPLE, 1'($urandom_range(0, 1)), 1'b0, '0);
            else if (pick < 91)
                send_req(MODE_READ, 1'($urandom_range(0, 1)), 1'b0, '0);
            else if (pick < 97)
                send_req(MODE_CLEAR, 1'($urandom_range(0, 1)), 1'b0, '0);
            else
                send_req(MODE_NONE, 1'($urandom_range(0, 1)), 1'b0, '0);
        end
    endtask

    initial
    begin : stimulus
        int unsigned drain;
        rst_n <= 1'b0;
        item_valid <= 1'b0;
        item <= '0;
        pin_en <= 1'b0;
        pin_val <= '0;
        cfg_we <= 1'b0;
        cfg_index <= REG_CHAR_BITS;
        cfg_data <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        build_plan();
        foreach (plan[i])
            run_row(plan[i]);
        directed_sent = sent_count;

        // Random phases
        while (sent_count - directed_sent < RANDOM_ITEMS)
            run_phase();

        // Drain and finish
        release_req();
        drain = 0;
        while (status_q.size() != 0 && drain < 2000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (8) @(posedge clk);
        if (fails == 0 && status_q.size() == 0)
            $display("tb_async_serial_receiver passed");
        else
            $display("tb_async_serial_receiver failed");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/asr_pkg.sv
hdl/asr_framer.sv
hdl/asr_rxbuf.sv
hdl/async_serial_receiver.sv
tb/tb_async_serial_receiver.sv
